>>> sv/fitr_pkg.sv
// ----------------------------------------------------------------------------
// fitr_pkg
// Shared types and constants of the filtered instruction trace ring.
// ----------------------------------------------------------------------------
package fitr_pkg;

    localparam int CMD_W      = 2;
    localparam int PC_W       = 32;
    localparam int OP_W       = 32;
    localparam int MODE_W     = 5;
    localparam int SEQ_W      = 64;
    localparam int MAX_W      = 7;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int SIZE_CFG_W = 11;

    localparam logic                  TRACE_ENABLE_RST = 1'b0;
    localparam logic [PC_W-1:0]       RANGE_LOW_RST    = 32'h0000_0000;
    localparam logic [PC_W-1:0]       RANGE_HIGH_RST   = 32'hFFFF_FFFF;
    localparam logic [SIZE_CFG_W-1:0] RING_SIZE_RST    = 11'd1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_RECORD  = 2'd0,
        CMD_READ    = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRACE_ENABLE = 2'd0,
        REG_RANGE_LOW    = 2'd1,
        REG_RANGE_HIGH   = 2'd2,
        REG_RING_SIZE    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic mod_start;
        logic wp_load;
        logic rd_size;
        logic rd_base;
        logic rd_issue;
        logic rd_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic read_req;
        logic size_wr;
        logic mod_done;
        logic empty;
        logic out_taken;
        logic out_last;
    } dp_status_t;

endpackage

>>> sv/fitr_req_if.sv
// ----------------------------------------------------------------------------
// fitr_req_if
// Request channel: one trace command per transfer.
// ----------------------------------------------------------------------------
interface fitr_req_if;
    import fitr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [PC_W-1:0]   fetch_pc;
    logic [OP_W-1:0]   fetch_opcode;
    logic [MODE_W-1:0] cpu_mode;
    logic [MAX_W-1:0]  read_max;

    modport source (
        output valid, command, fetch_pc, fetch_opcode, cpu_mode, read_max,
        input  ready
    );

    modport sink (
        input  valid, command, fetch_pc, fetch_opcode, cpu_mode, read_max,
        output ready
    );
endinterface

>>> sv/fitr_rsp_if.sv
// ----------------------------------------------------------------------------
// fitr_rsp_if
// Response channel: one trace entry per transfer.
// ----------------------------------------------------------------------------
interface fitr_rsp_if;
    import fitr_pkg::*;

    logic              valid;
    logic              ready;
    logic              entry_valid;
    logic [PC_W-1:0]   entry_pc;
    logic [OP_W-1:0]   entry_opcode;
    logic [MODE_W-1:0] entry_mode;
    logic [SEQ_W-1:0]  entry_sequence;
    logic [SEQ_W-1:0]  first_index;
    logic              last_entry;

    modport source (
        output valid, entry_valid, entry_pc, entry_opcode, entry_mode,
               entry_sequence, first_index, last_entry,
        input  ready
    );

    modport sink (
        input  valid, entry_valid, entry_pc, entry_opcode, entry_mode,
               entry_sequence, first_index, last_entry,
        output ready
    );
endinterface

>>> sv/fitr_mod.sv
// ----------------------------------------------------------------------------
// fitr_mod
// Bit-serial remainder of the 64-bit record count by the ring size.
// ----------------------------------------------------------------------------
module fitr_mod #(
    parameter int SW = 11
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fitr_pkg::SEQ_W-1:0] dividend,
    input  logic [SW-1:0]              divisor,
    output logic                       done,
    output logic [SW-1:0]              remainder
);
    import fitr_pkg::*;

    localparam int CNT_W = $clog2(SEQ_W + 1);

    logic [SEQ_W-1:0] quo_reg;
    logic [SW-1:0]    rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [SW:0]      trial;
    logic [SW:0]      rem_next;

    always_comb
    begin
        trial = {rem_reg, quo_reg[SEQ_W-1]};
        if (trial >= {1'b0, divisor})
        begin
            rem_next = trial - {1'b0, divisor};
        end
        else
        begin
            rem_next = trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SEQ_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SEQ_W-2:0], 1'b0};
            rem_reg <= rem_next[SW-1:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> sv/fitr_dp.sv
// ----------------------------------------------------------------------------
// fitr_dp
// Datapath: registers, counters, trace memory, read walker, output register.
// ----------------------------------------------------------------------------
module fitr_dp #(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fitr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fitr_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_fire,
    input  logic [fitr_pkg::CMD_W-1:0]     command,
    input  logic [fitr_pkg::PC_W-1:0]      fetch_pc,
    input  logic [fitr_pkg::OP_W-1:0]      fetch_opcode,
    input  logic [fitr_pkg::MODE_W-1:0]    cpu_mode,
    input  logic [fitr_pkg::MAX_W-1:0]     read_max,
    input  logic                           rsp_ready,
    input  fitr_pkg::ctrl_cmd_t            ctl,
    output fitr_pkg::dp_status_t           sts,
    output logic                           rsp_valid,
    output logic                           entry_valid,
    output logic [fitr_pkg::PC_W-1:0]      entry_pc,
    output logic [fitr_pkg::OP_W-1:0]      entry_opcode,
    output logic [fitr_pkg::MODE_W-1:0]    entry_mode,
    output logic [fitr_pkg::SEQ_W-1:0]     entry_sequence,
    output logic [fitr_pkg::SEQ_W-1:0]     first_index,
    output logic                           last_entry
);
    import fitr_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(DEPTH + 1);
    localparam int CW    = ((SW > MAX_W) ? SW : MAX_W) + 1;
    localparam int MEM_W = PC_W + OP_W + MODE_W + SEQ_W;

    logic                  trace_enable_reg;
    logic [PC_W-1:0]       range_low_reg;
    logic [PC_W-1:0]       range_high_reg;
    logic [SIZE_CFG_W-1:0] ring_size_reg;

    logic [SEQ_W-1:0] total_reg;
    logic [SEQ_W-1:0] seen_reg;
    logic [SW-1:0]    wp_reg;

    logic [MAX_W-1:0] want_reg;
    logic [MAX_W-1:0] n_reg;
    logic [MAX_W-1:0] idx_reg;
    logic [SEQ_W-1:0] first_reg;
    logic [SW-1:0]    slot_reg;
    logic [MEM_W-1:0] rd_data_reg;

    logic [MEM_W-1:0] mem [DEPTH];

    logic             out_valid_reg;
    logic             out_entry_valid_reg;
    logic [PC_W-1:0]  out_pc_reg;
    logic [OP_W-1:0]  out_opcode_reg;
    logic [MODE_W-1:0] out_mode_reg;
    logic [SEQ_W-1:0] out_seq_reg;
    logic [SEQ_W-1:0] out_first_reg;
    logic             out_last_reg;

    logic [SW-1:0]    eff_size;
    logic             rec_fire;
    logic             restart_fire;
    logic             in_range;
    logic             mem_wr;
    logic [SEQ_W-1:0] seen_inc;
    logic [SW-1:0]    wp_inc;
    logic [SW-1:0]    slot_inc;
    logic [MAX_W-1:0] want_sat;
    logic [CW-1:0]    lim;
    logic [MAX_W-1:0] n_calc;
    logic [CW-1:0]    slot_calc;
    logic             empty;
    logic             mod_done;
    logic [SW-1:0]    mod_rem;

    always_comb
    begin
        if (ring_size_reg == '0)
        begin
            eff_size = SW'(1);
        end
        else if (32'(ring_size_reg) > 32'(DEPTH))
        begin
            eff_size = SW'(DEPTH);
        end
        else
        begin
            eff_size = SW'(ring_size_reg);
        end
    end

    assign rec_fire     = in_fire && (command == CMD_RECORD) && trace_enable_reg;
    assign restart_fire = in_fire && (command == CMD_RESTART);
    assign in_range     = (fetch_pc >= range_low_reg) && (fetch_pc <= range_high_reg);
    assign mem_wr       = rec_fire && in_range;
    assign seen_inc     = seen_reg + SEQ_W'(1);
    assign wp_inc       = ((wp_reg + SW'(1)) == eff_size) ? '0 : wp_reg + SW'(1);
    assign slot_inc     = ((slot_reg + SW'(1)) == eff_size) ? '0 : slot_reg + SW'(1);
    assign want_sat     = (read_max > MAX_W'(MAX_READ)) ? MAX_W'(MAX_READ) : read_max;
    assign lim          = (CW'(eff_size) < CW'(want_reg)) ? CW'(eff_size) : CW'(want_reg);
    assign n_calc       = (total_reg < SEQ_W'(lim)) ? MAX_W'(total_reg) : MAX_W'(lim);
    assign slot_calc    = (CW'(wp_reg) >= CW'(n_reg)) ? CW'(wp_reg) - CW'(n_reg)
                        : CW'(wp_reg) + CW'(eff_size) - CW'(n_reg);
    assign empty        = (n_reg == '0);

    fitr_mod #(
        .SW (SW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctl.mod_start),
        .dividend  (total_reg),
        .divisor   (eff_size),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trace_enable_reg <= TRACE_ENABLE_RST;
            range_low_reg    <= RANGE_LOW_RST;
            range_high_reg   <= RANGE_HIGH_RST;
            ring_size_reg    <= RING_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TRACE_ENABLE: trace_enable_reg <= cfg_data[0];
                REG_RANGE_LOW:    range_low_reg    <= cfg_data[PC_W-1:0];
                REG_RANGE_HIGH:   range_high_reg   <= cfg_data[PC_W-1:0];
                REG_RING_SIZE:    ring_size_reg    <= cfg_data[SIZE_CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            seen_reg  <= '0;
            wp_reg    <= '0;
        end
        else if (restart_fire)
        begin
            total_reg <= '0;
            seen_reg  <= '0;
            wp_reg    <= '0;
        end
        else if (ctl.wp_load)
        begin
            wp_reg <= mod_rem;
        end
        else if (rec_fire)
        begin
            seen_reg <= seen_inc;
            if (in_range)
            begin
                total_reg <= total_reg + SEQ_W'(1);
                wp_reg    <= wp_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[wp_reg[AW-1:0]] <= {fetch_pc, fetch_opcode, cpu_mode, seen_inc};
        end
        if (ctl.rd_issue)
        begin
            rd_data_reg <= mem[slot_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (command == CMD_READ))
        begin
            want_reg <= want_sat;
        end
        if (ctl.rd_size)
        begin
            n_reg <= n_calc;
        end
        if (ctl.rd_base)
        begin
            first_reg <= total_reg - SEQ_W'(n_reg);
            slot_reg  <= slot_calc[SW-1:0];
            idx_reg   <= '0;
        end
        else if (ctl.rd_issue)
        begin
            slot_reg <= slot_inc;
            idx_reg  <= idx_reg + MAX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.rd_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_load)
        begin
            if (empty)
            begin
                out_entry_valid_reg <= 1'b0;
                out_pc_reg          <= '0;
                out_opcode_reg      <= '0;
                out_mode_reg        <= '0;
                out_seq_reg         <= '0;
                out_first_reg       <= '0;
                out_last_reg        <= 1'b1;
            end
            else
            begin
                out_entry_valid_reg <= 1'b1;
                {out_pc_reg, out_opcode_reg, out_mode_reg, out_seq_reg} <= rd_data_reg;
                out_first_reg       <= first_reg;
                out_last_reg        <= (idx_reg == n_reg);
            end
        end
    end

    assign sts.read_req  = in_fire && (command == CMD_READ);
    assign sts.size_wr   = cfg_we && (cfg_index == REG_RING_SIZE);
    assign sts.mod_done  = mod_done;
    assign sts.empty     = empty;
    assign sts.out_taken = out_valid_reg && rsp_ready;
    assign sts.out_last  = out_last_reg;

    assign rsp_valid      = out_valid_reg;
    assign entry_valid    = out_entry_valid_reg;
    assign entry_pc       = out_pc_reg;
    assign entry_opcode   = out_opcode_reg;
    assign entry_mode     = out_mode_reg;
    assign entry_sequence = out_seq_reg;
    assign first_index    = out_first_reg;
    assign last_entry     = out_last_reg;

endmodule

>>> sv/fitr_ctrl.sv
// ----------------------------------------------------------------------------
// fitr_ctrl
// Controller: accepts commands, sequences reads and ring-size updates.
// ----------------------------------------------------------------------------
module fitr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fitr_pkg::dp_status_t sts,
    output fitr_pkg::ctrl_cmd_t  ctl,
    output logic                 ready
);
    import fitr_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_MOD      = 7'b0000010,
        ST_RD_SIZE  = 7'b0000100,
        ST_RD_BASE  = 7'b0001000,
        ST_RD_ISSUE = 7'b0010000,
        ST_RD_LOAD  = 7'b0100000,
        ST_RD_HOLD  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
                if (sts.size_wr)
                begin
                    ctl.mod_start = 1'b1;
                    state_next    = ST_MOD;
                end
                else if (sts.read_req)
                begin
                    state_next = ST_RD_SIZE;
                end
            end
            ST_MOD:
            begin
                if (sts.mod_done)
                begin
                    ctl.wp_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_RD_SIZE:
            begin
                ctl.rd_size = 1'b1;
                state_next  = ST_RD_BASE;
            end
            ST_RD_BASE:
            begin
                ctl.rd_base = 1'b1;
                state_next  = sts.empty ? ST_RD_LOAD : ST_RD_ISSUE;
            end
            ST_RD_ISSUE:
            begin
                ctl.rd_issue = 1'b1;
                state_next   = ST_RD_LOAD;
            end
            ST_RD_LOAD:
            begin
                ctl.rd_load = 1'b1;
                state_next  = ST_RD_HOLD;
            end
            ST_RD_HOLD:
            begin
                if (sts.out_taken)
                begin
                    state_next = sts.out_last ? ST_IDLE : ST_RD_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/filtered_instruction_trace_ring.sv
// Filtered instruction trace ring. Record and restart commands can follow
// back to back. A read sizes its result and sets its base slot, then per entry
// reads the trace memory through its single read port, loads the one output
// register and waits for the transfer; an empty read skips the memory read and
// returns one result. A ring_size write made while idle starts a 64-step
// bit-serial remainder that recomputes the write slot; the request channel is
// held off until that slot is loaded. The user must read entries only where
// they were written since reset; the block does not enforce this, and after
// growing ring_size without a restart, older slots may not have been written.
// ----------------------------------------------------------------------------
// filtered_instruction_trace_ring
// Top level: trace ring with pc range filter and recent-entry readout.
// ----------------------------------------------------------------------------
module filtered_instruction_trace_ring #(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fitr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fitr_pkg::CFG_W-1:0]     cfg_data,
    fitr_req_if.sink                       request,
    fitr_rsp_if.source                     response
);
    import fitr_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t sts;
    logic       ready;

    assign request.ready = ready;

    fitr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl),
        .ready (ready)
    );

    fitr_dp #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_fire        (request.valid && ready),
        .command        (request.command),
        .fetch_pc       (request.fetch_pc),
        .fetch_opcode   (request.fetch_opcode),
        .cpu_mode       (request.cpu_mode),
        .read_max       (request.read_max),
        .rsp_ready      (response.ready),
        .ctl            (ctl),
        .sts            (sts),
        .rsp_valid      (response.valid),
        .entry_valid    (response.entry_valid),
        .entry_pc       (response.entry_pc),
        .entry_opcode   (response.entry_opcode),
        .entry_mode     (response.entry_mode),
        .entry_sequence (response.entry_sequence),
        .first_index    (response.first_index),
        .last_entry     (response.last_entry)
    );

endmodule

>>> sv/fitr_checker.sv
// ----------------------------------------------------------------------------
// fitr_checker
// Port-level checks of the trace ring, bound to the top level.
// ----------------------------------------------------------------------------
module fitr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic [fitr_pkg::CMD_W-1:0]    req_command,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic                          rsp_entry_valid,
    input logic [fitr_pkg::PC_W-1:0]     rsp_entry_pc,
    input logic [fitr_pkg::SEQ_W-1:0]    rsp_entry_sequence,
    input logic [fitr_pkg::SEQ_W-1:0]    rsp_first_index,
    input logic                          rsp_last_entry
);
    import fitr_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_pc)
            && $stable(rsp_entry_sequence) && $stable(rsp_last_entry))
        else $error("response changed while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request taken while a response is pending");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_command == CMD_READ) |=> !req_ready)
        else $error("request ready right after a read transfer");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_entry_valid |-> rsp_last_entry
            && (rsp_entry_pc == '0) && (rsp_first_index == '0))
        else $error("malformed empty read result");

endmodule

bind filtered_instruction_trace_ring fitr_checker u_fitr_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (request.valid),
    .req_ready          (request.ready),
    .req_command        (request.command),
    .rsp_valid          (response.valid),
    .rsp_ready          (response.ready),
    .rsp_entry_valid    (response.entry_valid),
    .rsp_entry_pc       (response.entry_pc),
    .rsp_entry_sequence (response.entry_sequence),
    .rsp_first_index    (response.first_index),
    .rsp_last_entry     (response.last_entry)
);

>>> tb/filtered_instruction_trace_ring_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// filtered_instruction_trace_ring_test
// Drives record, read, restart and unused commands into the trace ring under
// a series of filter ranges, enable states and ring sizes. A predictor keeps
// its own copy of the ring and counters and queues the entries each read
// should stream back. Every response transfer is checked field by field
// against the oldest queued entry.
// ----------------------------------------------------------------------------
module filtered_instruction_trace_ring_test;
    import fitr_pkg::*;

    localparam int               RING_DEPTH   = 1024;
    localparam int               MAX_READ_LEN = 64;
    localparam int               DRAIN_CYCLES = 16;
    localparam int               CYCLE_LIMIT  = 1000000;
    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

    localparam int IDLE_NONE     = 0;
    localparam int IDLE_SENDER   = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH     = 3;

    typedef struct {
        logic [CMD_W-1:0]  command;
        logic [PC_W-1:0]   pc;
        logic [OP_W-1:0]   opcode;
        logic [MODE_W-1:0] mode;
        logic [MAX_W-1:0]  want;
    } trace_command_t;

    typedef struct {
        logic              valid;
        logic [PC_W-1:0]   pc;
        logic [OP_W-1:0]   opcode;
        logic [MODE_W-1:0] mode;
        logic [SEQ_W-1:0]  seq_no;
        logic [SEQ_W-1:0]  first_idx;
        logic              is_last;
    } trace_entry_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    fitr_req_if req_ch ();
    fitr_rsp_if rsp_ch ();

    filtered_instruction_trace_ring DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .request  (req_ch),
        .response (rsp_ch)
    );

    // predictor state
    logic                  trace_on;
    logic [PC_W-1:0]       pc_low;
    logic [PC_W-1:0]       pc_high;
    logic [SIZE_CFG_W-1:0] size_setting;
    logic [PC_W-1:0]       ring_pc   [RING_DEPTH];
    logic [OP_W-1:0]       ring_op   [RING_DEPTH];
    logic [MODE_W-1:0]     ring_mode [RING_DEPTH];
    logic [SEQ_W-1:0]      ring_seq  [RING_DEPTH];
    logic [SEQ_W-1:0]      stored_count;
    logic [SEQ_W-1:0]      executed_count;

    trace_command_t queued_commands [$];
    trace_entry_t   awaited_entries [$];

    int   errors;
    int   cycle_count;
    int   sender_idle_pct;
    int   stall_pct;
    logic req_fire;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [SEQ_W-1:0] ring_span();
        if (size_setting == '0)
            return 1;
        if (size_setting > RING_DEPTH)
            return RING_DEPTH;
        return {53'b0, size_setting};
    endfunction

    function automatic void compute_trace_entries(trace_command_t c);
        logic [SEQ_W-1:0] span;
        logic [SEQ_W-1:0] slot;
        logic [SEQ_W-1:0] want;
        logic [SEQ_W-1:0] held;
        logic [SEQ_W-1:0] count;
        logic [SEQ_W-1:0] first;
        trace_entry_t     e;
        span = ring_span();
        case (c.command)
            CMD_RECORD:
            begin
                if (trace_on)
                begin
                    executed_count = executed_count + 1;
                    if (c.pc >= pc_low && c.pc <= pc_high)
                    begin
                        slot = stored_count % span;
                        ring_pc[slot]   = c.pc;
                        ring_op[slot]   = c.opcode;
                        ring_mode[slot] = c.mode;
                        ring_seq[slot]  = executed_count;
                        stored_count    = stored_count + 1;
                    end
                end
            end
            CMD_READ:
            begin
                want = (c.want > MAX_READ_LEN) ? MAX_READ_LEN : {57'b0, c.want};
                if (stored_count == '0 || want == '0)
                begin
                    e = '{default: '0};
                    e.is_last = 1'b1;
                    awaited_entries.push_back(e);
                end
                else
                begin
                    held  = (stored_count > span) ? span : stored_count;
                    count = (held < want) ? held : want;
                    first = stored_count - count;
                    for (logic [SEQ_W-1:0] i = 0; i < count; i++)
                    begin
                        slot        = (first + i) % span;
                        e.valid     = 1'b1;
                        e.pc        = ring_pc[slot];
                        e.opcode    = ring_op[slot];
                        e.mode      = ring_mode[slot];
                        e.seq_no    = ring_seq[slot];
                        e.first_idx = first;
                        e.is_last   = (i + 1 == count);
                        awaited_entries.push_back(e);
                    end
                end
            end
            CMD_RESTART:
            begin
                stored_count   = '0;
                executed_count = '0;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function automatic void check_entry(trace_entry_t got);
        trace_entry_t want;
        if (awaited_entries.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected transfer, expected none, actual valid %0b pc %0h seq %0h",
                     $time, got.valid, got.pc, got.seq_no);
        end
        else
        begin
            want = awaited_entries.pop_front();
            check_field("entry_valid", want.valid, got.valid);
            check_field("entry_pc", want.pc, got.pc);
            check_field("entry_opcode", want.opcode, got.opcode);
            check_field("entry_mode", want.mode, got.mode);
            check_field("entry_sequence", want.seq_no, got.seq_no);
            check_field("first_index", want.first_idx, got.first_idx);
            check_field("last_entry", want.is_last, got.is_last);
        end
    endfunction

    // monitor: sample both channels at the rising edge
    always @(posedge clk)
    begin : monitor
        trace_command_t c;
        trace_entry_t   r;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("filtered_instruction_trace_ring test failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                c.command = req_ch.command;
                c.pc      = req_ch.fetch_pc;
                c.opcode  = req_ch.fetch_opcode;
                c.mode    = req_ch.cpu_mode;
                c.want    = req_ch.read_max;
                compute_trace_entries(c);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                r.valid     = rsp_ch.entry_valid;
                r.pc        = rsp_ch.entry_pc;
                r.opcode    = rsp_ch.entry_opcode;
                r.mode      = rsp_ch.entry_mode;
                r.seq_no    = rsp_ch.entry_sequence;
                r.first_idx = rsp_ch.first_index;
                r.is_last   = rsp_ch.last_entry;
                check_entry(r);
            end
        end
        req_fire <= req_ch.valid && req_ch.ready;
    end

    // driver: advance the request channel and toggle ready at the falling edge
    always @(negedge clk)
    begin : driver
        trace_command_t c;
        if (!req_ch.valid || req_fire)
        begin
            if (queued_commands.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                c = queued_commands.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.command      <= c.command;
                req_ch.fetch_pc     <= c.pc;
                req_ch.fetch_opcode <= c.opcode;
                req_ch.cpu_mode     <= c.mode;
                req_ch.read_max     <= c.want;
            end
            else
                req_ch.valid <= 1'b0;
        end
        rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic void push_command(logic [CMD_W-1:0] cmd, logic [PC_W-1:0] pc,
                                         logic [OP_W-1:0] op, logic [MODE_W-1:0] mode,
                                         logic [MAX_W-1:0] want);
        trace_command_t c;
        c.command = cmd;
        c.pc      = pc;
        c.opcode  = op;
        c.mode    = mode;
        c.want    = want;
        queued_commands.push_back(c);
    endfunction

    function automatic logic [PC_W-1:0] pick_pc();
        int               r;
        logic [SEQ_W-1:0] span;
        r = $urandom_range(0, 99);
        if (pc_low <= pc_high && r < 75)
        begin
            span = {32'b0, pc_high} - {32'b0, pc_low} + 1;
            return pc_low + PC_W'({$urandom, $urandom} % span);
        end
        if (r < 80)
            return pc_low;
        if (r < 85)
            return pc_high;
        if (r < 90)
            return pc_low - 1;
        if (r < 95)
            return pc_high + 1;
        return $urandom;
    endfunction

    function automatic logic [MAX_W-1:0] pick_read_max();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        if (r < 16)
            return MAX_W'($urandom_range(65, 127));
        if (r < 28)
            return MAX_W'(MAX_READ_LEN);
        return MAX_W'($urandom_range(1, 20));
    endfunction

    function automatic void queue_random_commands(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                push_command(CMD_RECORD, pick_pc(), $urandom, MODE_W'($urandom_range(0, 31)),
                             MAX_W'($urandom_range(0, 127)));
            else if (r < 88)
                push_command(CMD_READ, $urandom, $urandom, MODE_W'($urandom_range(0, 31)),
                             pick_read_max());
            else if (r < 94)
                push_command(CMD_RESTART, $urandom, $urandom, MODE_W'($urandom_range(0, 31)),
                             MAX_W'($urandom_range(0, 127)));
            else
                push_command(CMD_UNUSED, $urandom, $urandom, MODE_W'($urandom_range(0, 31)),
                             MAX_W'($urandom_range(0, 127)));
        end
    endfunction

    task automatic wait_idle();
        while (queued_commands.size() != 0 || req_ch.valid || awaited_entries.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            IDLE_SENDER:   begin sender_idle_pct = 62; stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  stall_pct = 62; end
            IDLE_BOTH:     begin sender_idle_pct = 7;  stall_pct = 7;  end
            default:       begin sender_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    task automatic write_register(cfg_reg_t idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_TRACE_ENABLE: trace_on     = data[0];
            REG_RANGE_LOW:    pc_low       = data;
            REG_RANGE_HIGH:   pc_high      = data;
            REG_RING_SIZE:    size_setting = data[SIZE_CFG_W-1:0];
            default:          ;
        endcase
    endtask

    // write ring_size last; restart after growth so no stale slot is read
    task automatic configure(logic en, logic [PC_W-1:0] lo, logic [PC_W-1:0] hi,
                             logic [SIZE_CFG_W-1:0] size);
        logic [SEQ_W-1:0] old_span;
        wait_idle();
        old_span = ring_span();
        write_register(REG_TRACE_ENABLE, {31'b0, en});
        write_register(REG_RANGE_LOW, lo);
        write_register(REG_RANGE_HIGH, hi);
        write_register(REG_RING_SIZE, {21'b0, size});
        @(negedge clk);
        cfg_we <= 1'b0;
        if (ring_span() > old_span)
            push_command(CMD_RESTART, '0, '0, '0, '0);
    endtask

    initial
    begin : stimulus
        logic [PC_W-1:0] lo;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_TRACE_ENABLE;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.command      = CMD_RECORD;
        req_ch.fetch_pc     = '0;
        req_ch.fetch_opcode = '0;
        req_ch.cpu_mode     = '0;
        req_ch.read_max     = '0;
        rsp_ch.ready        = 1'b0;
        req_fire            = 1'b0;
        errors              = 0;
        cycle_count         = 0;
        sender_idle_pct     = 0;
        stall_pct           = 0;
        trace_on            = TRACE_ENABLE_RST;
        pc_low              = RANGE_LOW_RST;
        pc_high             = RANGE_HIGH_RST;
        size_setting        = RING_SIZE_RST;
        stored_count        = '0;
        executed_count      = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // tracing off after reset: records ignored, read is empty
        set_idling(IDLE_NONE);
        push_command(CMD_RECORD, 32'h0000_0000, 32'h1234_5678, 5'd3, 7'd0);
        push_command(CMD_RECORD, 32'hFFFF_FFFF, 32'h8765_4321, 5'd9, 7'd0);
        push_command(CMD_READ, '0, '0, '0, 7'd3);
        push_command(CMD_UNUSED, 32'h0000_0150, 32'hDEAD_BEEF, 5'd1, 7'd5);

        // range edges, empty and saturated reads, wrap of a four-entry ring
        configure(1'b1, 32'h0000_0100, 32'h0000_01FF, 11'd4);
        push_command(CMD_RECORD, 32'h0000_00FF, 32'h0000_0001, 5'd2, 7'd0);
        push_command(CMD_RECORD, 32'h0000_0100, 32'hFFFF_FFFF, 5'd31, 7'd0);
        push_command(CMD_RECORD, 32'h0000_01FF, 32'h0000_0000, 5'd0, 7'd0);
        push_command(CMD_RECORD, 32'h0000_0200, 32'h0000_0002, 5'd4, 7'd0);
        push_command(CMD_READ, '0, '0, '0, 7'd0);
        push_command(CMD_READ, '0, '0, '0, 7'd1);
        push_command(CMD_READ, '0, '0, '0, 7'd127);
        push_command(CMD_RECORD, 32'h0000_0150, 32'hA5A5_0001, 5'd5, 7'd0);
        push_command(CMD_RECORD, 32'h0000_0160, 32'hA5A5_0002, 5'd6, 7'd0);
        push_command(CMD_RECORD, 32'h0000_0170, 32'hA5A5_0003, 5'd7, 7'd0);
        push_command(CMD_RECORD, 32'h0000_0180, 32'hA5A5_0004, 5'd8, 7'd0);
        push_command(CMD_READ, '0, '0, '0, 7'd64);
        push_command(CMD_RESTART, '0, '0, '0, '0);
        push_command(CMD_READ, '0, '0, '0, 7'd5);
        push_command(CMD_RECORD, 32'h0000_01AB, 32'h5A5A_5A5A, 5'd21, 7'd0);
        push_command(CMD_READ, '0, '0, '0, 7'd2);

        configure(1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 11'd0);
        set_idling(IDLE_SENDER);
        queue_random_commands(48);

        lo = $urandom;
        configure(1'b1, lo, (lo > 32'hFFFF_F000) ? 32'hFFFF_FFFF : lo + $urandom_range(0, 4095),
                  11'd16);
        set_idling(IDLE_RECEIVER);
        queue_random_commands(48);

        configure(1'b1, 32'h0000_0000, 32'h0000_0000, 11'd2047);
        set_idling(IDLE_BOTH);
        queue_random_commands(48);

        configure(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd7);
        set_idling(IDLE_NONE);
        queue_random_commands(48);

        configure(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd7);
        set_idling(IDLE_SENDER);
        queue_random_commands(48);

        configure(1'b1, $urandom, $urandom, 11'd1024);
        set_idling(IDLE_RECEIVER);
        queue_random_commands(48);

        configure(1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 11'd64);
        set_idling(IDLE_BOTH);
        queue_random_commands(48);

        wait_idle();
        if (awaited_entries.size() != 0)
            $display("%0t: %0d entries expected, actual none; next expected pc %0h seq %0h",
                     $time, awaited_entries.size(), awaited_entries[0].pc,
                     awaited_entries[0].seq_no);
        if (errors == 0 && awaited_entries.size() == 0)
            $display("filtered_instruction_trace_ring test passed");
        else
            $display("filtered_instruction_trace_ring test failed");
        $finish;
    end

endmodule

>>> sim.f
sv/fitr_pkg.sv
sv/fitr_req_if.sv
sv/fitr_rsp_if.sv
sv/fitr_mod.sv
sv/fitr_dp.sv
sv/fitr_ctrl.sv
sv/filtered_instruction_trace_ring.sv
sv/fitr_checker.sv
tb/filtered_instruction_trace_ring_test.sv
